// ----- src/seconds_to_calendar_date_assert.svh -----
// Assertion macros for the seconds to calendar date block.
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define STCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define STCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STCD_ASSERT_IMP(label, ante, cons)
`define STCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/stcd_pkg.sv -----
// Shared constants, types and the month-length table of the calendar converter.
package stcd_pkg;

  localparam int unsigned SecsW  = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned YearW  = 7;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  // 36525 days times 86400 seconds
  localparam logic [SecsW-1:0] SECS_IN_RANGE = 32'd3155760000;

  localparam logic [SecsW-1:0] DIV_DAY_C  = 32'd86400;
  localparam logic [SecsW-1:0] DIV_HOUR_C = 32'd3600;
  localparam logic [SecsW-1:0] DIV_MIN_C  = 32'd60;

  // floor(2^48/86400), floor(2^43/3600), floor(2^37/60)
  localparam logic [31:0] RECIP_DAY  = 32'd3257812230;
  localparam logic [31:0] RECIP_HOUR = 32'd2443359172;
  localparam logic [31:0] RECIP_MIN  = 32'd2290649224;

  localparam logic [MonthW-1:0] LAST_MONTH = 4'd12;
  localparam logic [MonthW-1:0] FEBRUARY   = 4'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_BACK,
    OP_FIX,
    OP_YEAR,
    OP_MONTH,
    OP_WRITE
  } op_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_e;

  typedef struct packed {
    op_e  op;
    div_e div;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic year_done;
    logic month_done;
  } status_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon);
    logic [DayW-1:0] len;
    case (mon)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- src/stcd_datapath.sv -----
// Datapath: constant dividers, year and month peeling, result registers.
module stcd_datapath (
  input  logic                           clk_i,
  input  stcd_pkg::cmd_t                 cmd_i,
  input  logic [stcd_pkg::SecsW-1:0]     elapsed_seconds_i,
  output stcd_pkg::status_t              status_o,
  output logic [stcd_pkg::YearW-1:0]     year_offset_o,
  output logic [stcd_pkg::MonthW-1:0]    month_o,
  output logic [stcd_pkg::DayW-1:0]      day_of_month_o,
  output logic [stcd_pkg::HourW-1:0]     hour_o,
  output logic [stcd_pkg::MinW-1:0]      minute_o,
  output logic [stcd_pkg::SecW-1:0]      second_o,
  output logic                           out_of_range_o
);
  import stcd_pkg::*;

  logic [SecsW-1:0]  x_q;
  logic [63:0]       prod_q;
  logic [DaysW-1:0]  quo_q;
  logic [SecsW-1:0]  back_q;
  logic [DaysW-1:0]  days_q;
  logic [HourW-1:0]  hr_q;
  logic [MinW-1:0]   mn_q;
  logic [SecW-1:0]   sc_q;
  logic [YearW-1:0]  yoff_q;
  logic [MonthW-1:0] mon_q;
  logic              oor_q;

  logic [31:0]       recip;
  logic [SecsW-1:0]  divisor;
  logic [DaysW-1:0]  q_est;
  logic [SecsW-1:0]  rem_raw;
  logic [SecsW-1:0]  rem_fix;
  logic [DaysW-1:0]  quo_fix;
  logic              leap;
  logic [8:0]        ylen;
  logic [DayW-1:0]   mlen;

  always_comb begin
    case (cmd_i.div)
      DIV_DAY: begin
        recip   = RECIP_DAY;
        divisor = DIV_DAY_C;
        q_est   = prod_q[63:48];
      end
      DIV_HOUR: begin
        recip   = RECIP_HOUR;
        divisor = DIV_HOUR_C;
        q_est   = DaysW'(prod_q[48:43]);
      end
      default: begin
        recip   = RECIP_MIN;
        divisor = DIV_MIN_C;
        q_est   = DaysW'(prod_q[43:37]);
      end
    endcase
  end

  // estimate is exact or one short
  assign rem_raw = x_q - back_q;
  always_comb begin
    if (rem_raw >= divisor) begin
      rem_fix = rem_raw - divisor;
      quo_fix = quo_q + DaysW'(1);
    end else begin
      rem_fix = rem_raw;
      quo_fix = quo_q;
    end
  end

  assign leap = (yoff_q[1:0] == 2'b00);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_q) + DayW'(leap && (mon_q == FEBRUARY));

  assign status_o.oor        = oor_q;
  assign status_o.year_done  = days_q < DaysW'(ylen);
  assign status_o.month_done = (days_q < DaysW'(mlen)) || (mon_q >= LAST_MONTH);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q    <= elapsed_seconds_i;
        oor_q  <= elapsed_seconds_i >= SECS_IN_RANGE;
        yoff_q <= '0;
        mon_q  <= MonthW'(1);
      end
      OP_MUL: prod_q <= 64'(x_q) * 64'(recip);
      OP_BACK: begin
        quo_q  <= q_est;
        back_q <= SecsW'(q_est) * divisor;
      end
      OP_FIX: begin
        case (cmd_i.div)
          DIV_DAY: begin
            days_q <= quo_fix;
            x_q    <= rem_fix;
          end
          DIV_HOUR: begin
            hr_q <= quo_fix[HourW-1:0];
            x_q  <= rem_fix;
          end
          default: begin
            mn_q <= quo_fix[MinW-1:0];
            sc_q <= rem_fix[SecW-1:0];
          end
        endcase
      end
      OP_YEAR: begin
        days_q <= days_q - DaysW'(ylen);
        yoff_q <= yoff_q + YearW'(1);
      end
      OP_MONTH: begin
        days_q <= days_q - DaysW'(mlen);
        mon_q  <= mon_q + MonthW'(1);
      end
      OP_WRITE: begin
        out_of_range_o <= oor_q;
        if (oor_q) begin
          year_offset_o  <= '0;
          month_o        <= '0;
          day_of_month_o <= '0;
          hour_o         <= '0;
          minute_o       <= '0;
          second_o       <= '0;
        end else begin
          year_offset_o  <= yoff_q;
          month_o        <= mon_q;
          day_of_month_o <= days_q[DayW-1:0] + DayW'(1);
          hour_o         <= hr_q;
          minute_o       <= mn_q;
          second_o       <= sc_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/stcd_controller.sv -----
// Controller: sequences the divisions, the year and month loops and both handshakes.
module stcd_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  stcd_pkg::status_t status_i,
  output stcd_pkg::cmd_t    cmd_o
);
  import stcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BACK,
    S_FIX,
    S_YEAR,
    S_MONTH,
    S_WRITE
  } state_e;

  state_e state_q;
  div_e   div_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.div = div_q;
    case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_MUL:   cmd_o.op = status_i.oor ? OP_NONE : OP_MUL;
      S_BACK:  cmd_o.op = OP_BACK;
      S_FIX:   cmd_o.op = OP_FIX;
      S_YEAR:  cmd_o.op = status_i.year_done ? OP_NONE : OP_YEAR;
      S_MONTH: cmd_o.op = status_i.month_done ? OP_NONE : OP_MONTH;
      S_WRITE: cmd_o.op = out_free ? OP_WRITE : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_q       <= DIV_DAY;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (state_q == S_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          div_q <= DIV_DAY;
          if (in_valid_i) state_q <= S_MUL;
        end
        S_MUL:   state_q <= status_i.oor ? S_WRITE : S_BACK;
        S_BACK:  state_q <= S_FIX;
        S_FIX: begin
          case (div_q)
            DIV_DAY: begin
              div_q   <= DIV_HOUR;
              state_q <= S_MUL;
            end
            DIV_HOUR: begin
              div_q   <= DIV_MIN;
              state_q <= S_MUL;
            end
            default: state_q <= S_YEAR;
          endcase
        end
        S_YEAR:  if (status_i.year_done) state_q <= S_MONTH;
        S_MONTH: if (status_i.month_done) state_q <= S_WRITE;
        S_WRITE: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/seconds_to_calendar_date.sv -----
// Top level of the seconds to calendar date converter.
//
// Input channel: in_valid_i / in_stall_o carry elapsed_seconds_i, seconds since
// 2000-01-01 00:00:00. A transaction completes on a rising edge with valid high
// and stall low. Output channel: out_valid_o / out_stall_i carry the date and
// time fields and out_of_range_o, one result per input.
// One item at a time: stall is raised from acceptance until the result has
// been loaded into the output register. Each of the three divisions passes
// through the multiply, back and fix states; whole years (0..99) are then
// peeled one at a time, then months (0..11), and the result is loaded.
// Inputs past 2099 skip straight from the multiply state to the output. The
// next transaction is taken the cycle after loading.
// The output register parts the two sides: a new transaction is taken while a
// result still waits; the finished next result waits in the sequencer until
// the receiver stops stalling. A stalled result holds its fields.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// out_valid_o; payload registers are not reset.
module seconds_to_calendar_date (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [stcd_pkg::SecsW-1:0]  elapsed_seconds_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [stcd_pkg::YearW-1:0]  year_offset_o,
  output logic [stcd_pkg::MonthW-1:0] month_o,
  output logic [stcd_pkg::DayW-1:0]   day_of_month_o,
  output logic [stcd_pkg::HourW-1:0]  hour_o,
  output logic [stcd_pkg::MinW-1:0]   minute_o,
  output logic [stcd_pkg::SecW-1:0]   second_o,
  output logic                        out_of_range_o
);
  import stcd_pkg::*;

  `include "seconds_to_calendar_date_assert.svh"

  cmd_t    cmd;
  status_t status;
  logic    fields_zero;
  logic    fields_legal;

  // sequencer: owns both handshakes and steps the datapath
  stcd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // reciprocal dividers, year/month peeling and the output register
  stcd_datapath u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .elapsed_seconds_i (elapsed_seconds_i),
    .status_o          (status),
    .year_offset_o     (year_offset_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o),
    .hour_o            (hour_o),
    .minute_o          (minute_o),
    .second_o          (second_o),
    .out_of_range_o    (out_of_range_o)
  );

  assign fields_zero  = (year_offset_o == '0) && (month_o == '0) && (day_of_month_o == '0) &&
                        (hour_o == '0) && (minute_o == '0) && (second_o == '0);
  assign fields_legal = (year_offset_o <= YearW'(99)) && (month_o >= MonthW'(1)) &&
                        (month_o <= LAST_MONTH) && (day_of_month_o >= DayW'(1)) &&
                        (hour_o <= HourW'(23)) && (minute_o <= MinW'(59)) &&
                        (second_o <= SecW'(59));

  // busy straight after a transaction is taken
  `STCD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // out-of-range results carry zero fields
  `STCD_ASSERT_IMP(a_oor_zero, out_valid_o && out_of_range_o, fields_zero)
  // in-range results are a legal date and time
  `STCD_ASSERT_IMP(a_fields_legal, out_valid_o && !out_of_range_o, fields_legal)

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the seconds to calendar date converter.
module tb;

  import stcd_pkg::*;

  // Cycles without any transaction on either side before the run is abandoned.
  // Slowest correct item is the longest conversion plus long stall runs.
  localparam int unsigned WatchdogLimit = 3000;
  // Quiet time after the last result, a little over the longest conversion.
  localparam int unsigned DrainCycles   = 140;
  localparam int unsigned RandomItems   = 800;
  localparam int unsigned MaxReported   = 10;

  // One converted date and time, laid out as the output ports.
  typedef struct packed {
    logic              oor;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
  } calendar_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [SecsW-1:0]  elapsed_seconds = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [YearW-1:0]  year_offset;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day_of_month;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;
  logic              out_of_range;

  // Seconds values still to be offered, and dates awaited from the block.
  logic [SecsW-1:0] seconds_q [$];
  calendar_t        date_q [$];

  int unsigned item_total   = 0;
  int unsigned accepted_in  = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  calendar_t got_date;
  calendar_t want_date;

  seconds_to_calendar_date dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .elapsed_seconds_i (elapsed_seconds),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .year_offset_o     (year_offset),
    .month_o           (month),
    .day_of_month_o    (day_of_month),
    .hour_o            (hour),
    .minute_o          (minute),
    .second_o          (second),
    .out_of_range_o    (out_of_range)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Days in a month (1 is January); February gains a day in leap years.
  function automatic int unsigned days_in_month(input int unsigned mon, input logic leap);
    int unsigned len;
    case (mon)
      2:             len = leap ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // Day count from 2000-01-01 to the first of month mon in year 2000+yr.
  // Every fourth year from 2000 is a leap year across the whole range.
  function automatic int unsigned first_day_of(input int unsigned yr, input int unsigned mon);
    int unsigned days;
    int unsigned m;
    days = 365 * yr + (yr + 3) / 4;
    for (m = 1; m < mon; m++) days += days_in_month(m, (yr % 4) == 0);
    return days;
  endfunction

  // Expected date and time for a count of seconds.
  // Time of day comes off by plain division; years, then months, are peeled
  // from the remaining day count. Beyond 2099 only the range flag is set.
  function automatic calendar_t to_calendar(input logic [SecsW-1:0] secs);
    calendar_t   c;
    int unsigned rest;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    logic        leap;
    c = '0;
    if (secs >= SECS_IN_RANGE) begin
      c.oor = 1'b1;
      return c;
    end
    c.second = SecW'(secs % 60);
    rest     = secs / 60;
    c.minute = MinW'(rest % 60);
    rest     = rest / 60;
    c.hour   = HourW'(rest % 24);
    days     = rest / 24;
    yr       = 0;
    leap     = 1'b1;
    while (days >= (leap ? 366 : 365)) begin
      days -= leap ? 366 : 365;
      yr++;
      leap = (yr % 4) == 0;
    end
    mon = 1;
    while (mon < 12 && days >= days_in_month(mon, leap)) begin
      days -= days_in_month(mon, leap);
      mon++;
    end
    c.year  = YearW'(yr);
    c.month = MonthW'(mon);
    c.day   = DayW'(days + 1);
    return c;
  endfunction

  // Idling schedule, keyed on how far through the stimulus the sender is:
  // a busy sender against a mostly stalling receiver, then the reverse, then flat out.
  always_comb begin
    if (accepted_in * 3 < item_total) begin
      tx_idle_pct = 21;
      rx_idle_pct = 80;
    end else if (accepted_in * 3 < item_total * 2) begin
      tx_idle_pct = 80;
      rx_idle_pct = 21;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Stimulus, then the end-of-run verdict.
  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned yr;
    int unsigned mon;
    longint      t;

    // Directed: field extremes, rollovers of each unit, leap days, month
    // and year ends, the last in-range second and the first one beyond.
    seconds_q.push_back(32'd0);
    seconds_q.push_back(32'd59);
    seconds_q.push_back(32'd60);
    seconds_q.push_back(32'd3599);
    seconds_q.push_back(32'd3600);
    seconds_q.push_back(32'd86399);
    seconds_q.push_back(32'd86400);
    seconds_q.push_back((first_day_of(0, 3) - 1) * 86400 + 43200);  // 29 Feb 2000
    seconds_q.push_back(first_day_of(1, 1) * 86400 - 1);            // end of 2000
    seconds_q.push_back(first_day_of(1, 1) * 86400);                // start of 2001
    seconds_q.push_back(first_day_of(1, 3) * 86400 - 1);            // 28 Feb 2001, late
    seconds_q.push_back(first_day_of(1, 3) * 86400);                // 1 Mar 2001
    seconds_q.push_back((first_day_of(4, 3) - 1) * 86400);          // 29 Feb 2004
    seconds_q.push_back(first_day_of(3, 5) * 86400 - 1);            // 30 Apr 2003, late
    seconds_q.push_back(first_day_of(50, 7) * 86400 + 14 * 86400 + 45296);
    seconds_q.push_back(first_day_of(99, 1) * 86400);               // start of 2099
    seconds_q.push_back(SECS_IN_RANGE - 1);
    seconds_q.push_back(SECS_IN_RANGE);
    seconds_q.push_back(32'hFFFF_FFFF);
    seconds_q.push_back(32'h5555_5555);
    seconds_q.push_back(32'hAAAA_AAAA);

    // Random: mostly in range, a good share sitting on month and year
    // boundaries, the rest anywhere in 32 bits or past the end of 2099.
    for (n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        seconds_q.push_back($urandom_range(0, SECS_IN_RANGE - 1));
      end else if (pick < 75) begin
        yr  = $urandom_range(0, 99);
        mon = $urandom_range(1, 12);
        t   = longint'(first_day_of(yr, mon)) * 86400 + $urandom_range(0, 4) - 2;
        seconds_q.push_back(t[SecsW-1:0]);
      end else if (pick < 90) begin
        seconds_q.push_back($urandom);
      end else if (pick < 95) begin
        seconds_q.push_back(SECS_IN_RANGE + $urandom_range(0, 4) - 2);
      end else begin
        seconds_q.push_back($urandom_range(SECS_IN_RANGE, 32'hFFFF_FFFF));
      end
    end
    item_total = seconds_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything offered and taken, every date back.
    do @(posedge clk_i);
    while (seconds_q.size() != 0 || in_valid || date_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver: a held item stays put until taken; a fresh one is offered
  // unless the sender chooses to idle this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid        <= 1'b0;
      elapsed_seconds <= '0;
      accepted_in     <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        date_q.push_back(to_calendar(elapsed_seconds));
        accepted_in <= accepted_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (seconds_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid        <= 1'b1;
          elapsed_seconds <= seconds_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(0, 99) < rx_idle_pct;
    end
  end

  // Monitor: every completed output transaction against the oldest date due.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got_date = '{oor: out_of_range, year: year_offset, month: month, day: day_of_month,
                   hour: hour, minute: minute, second: second};
      if (date_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MaxReported)
          $display("unexpected result: %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                   got_date.year, got_date.month, got_date.day, got_date.hour,
                   got_date.minute, got_date.second, got_date.oor);
      end else begin
        want_date = date_q.pop_front();
        if (got_date.oor    !== want_date.oor    || got_date.year   !== want_date.year   ||
            got_date.month  !== want_date.month  || got_date.day    !== want_date.day    ||
            got_date.hour   !== want_date.hour   || got_date.minute !== want_date.minute ||
            got_date.second !== want_date.second) begin
          mismatches <= mismatches + 1;
          if (mismatches < MaxReported)
            $display({"mismatch: want %0d-%0d-%0d %0d:%0d:%0d oor=%0b, ",
                      "got %0d-%0d-%0d %0d:%0d:%0d oor=%0b"},
                     want_date.year, want_date.month, want_date.day, want_date.hour,
                     want_date.minute, want_date.second, want_date.oor,
                     got_date.year, got_date.month, got_date.day, got_date.hour,
                     got_date.minute, got_date.second, got_date.oor);
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/stcd_pkg.sv
src/stcd_datapath.sv
src/stcd_controller.sv
src/seconds_to_calendar_date.sv
bench/tb.sv
